/* src/actuator_command_retry_supervisor_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the actuator command retry supervisor
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ACTUATOR_COMMAND_RETRY_SUPERVISOR_UNIT_DEFINES_SVH
`define ACTUATOR_COMMAND_RETRY_SUPERVISOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("acsu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("acsu: next-cycle check failed");

`endif

/* src/acsu_pkg.sv */
// ----------------------------------------------------------------------------
// Actuator command retry supervisor package
// Types, codes and constants shared by the supervisor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acsu_pkg;

	localparam int TIMEOUT_W   = 16;
	localparam int RETRY_W     = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 1;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd7;
	localparam logic [RETRY_W-1:0]   RETRY_RESET   = 4'd3;
	localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RETRIES   = 1'b1;

	localparam logic OP_POLL  = 1'b0;
	localparam logic OP_START = 1'b1;

	localparam logic [1:0] CMD_STOP    = 2'd0;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	localparam logic [2:0] STEP_CODE_IDLE  = 3'd0;
	localparam logic [2:0] STEP_CODE_WAIT  = 3'd1;
	localparam logic [2:0] STEP_CODE_RETRY = 3'd2;
	localparam logic [2:0] STEP_CODE_DONE  = 3'd3;
	localparam logic [2:0] STEP_CODE_FAIL  = 3'd4;

	typedef enum logic [4:0] {
		STEP_IDLE  = 5'b00001,
		STEP_WAIT  = 5'b00010,
		STEP_RETRY = 5'b00100,
		STEP_DONE  = 5'b01000,
		STEP_FAIL  = 5'b10000
	} step_t;

	typedef struct packed {
		logic       operation;
		logic [1:0] command;
		logic [1:0] sensed_position;
		logic       power_active;
	} item_t;

	typedef struct packed {
		logic       send_command;
		logic [1:0] command_out;
		logic [2:0] step_now;
		logic       busy_res;
		logic       error_event;
		logic       power_request;
	} result_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [RETRY_W-1:0]   max_retries;
	} cfg_t;

	typedef struct packed {
		step_t                step;
		logic                 busy;
		logic [1:0]           target;
		logic [RETRY_W-1:0]   retry_cnt;
		logic [TIMEOUT_W-1:0] elapsed;
	} sup_state_t;

	function automatic logic [2:0] step_code(input step_t step);
		logic [2:0] code;
		unique case (step)
			STEP_IDLE:  code = STEP_CODE_IDLE;
			STEP_WAIT:  code = STEP_CODE_WAIT;
			STEP_RETRY: code = STEP_CODE_RETRY;
			STEP_DONE:  code = STEP_CODE_DONE;
			STEP_FAIL:  code = STEP_CODE_FAIL;
			default:    code = STEP_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

/* src/acsu_channels.sv */
// ----------------------------------------------------------------------------
// Actuator command retry supervisor channels
// Valid/ready interfaces for the input item and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acsu_item_if import acsu_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface acsu_result_if import acsu_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* src/acsu_step_logic.sv */
// ----------------------------------------------------------------------------
// Actuator command retry supervisor step logic
// Next state and result for one registered item, given the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acsu_step_logic import acsu_pkg::*; (
	input  sup_state_t state_cur,
	input  cfg_t       cfg,
	input  item_t      item_cur,
	output sup_state_t state_nxt,
	output result_t    res_nxt
);

	logic [1:0]           cmd_eff;
	logic [TIMEOUT_W-1:0] elapsed_inc;
	logic                 timed_out;
	logic                 pos_match;
	logic                 send;
	logic                 err;
	logic                 preq;

	assign cmd_eff     = (item_cur.command == CMD_INVALID) ? CMD_STOP : item_cur.command;
	assign elapsed_inc = (state_cur.elapsed == ELAPSED_MAX) ? state_cur.elapsed
		: state_cur.elapsed + 1'b1;
	assign timed_out   = elapsed_inc >= cfg.timeout_ticks;
	assign pos_match   = item_cur.sensed_position == state_cur.target;

	always_comb begin
		state_nxt = state_cur;
		send      = 1'b0;
		err       = 1'b0;
		preq      = 1'b0;
		if (item_cur.operation == OP_START) begin
			state_nxt.target    = cmd_eff;
			state_nxt.busy      = 1'b1;
			state_nxt.retry_cnt = '0;
			state_nxt.elapsed   = '0;
			state_nxt.step      = STEP_WAIT;
			send                = item_cur.sensed_position != cmd_eff;
		end else if (!item_cur.power_active) begin
			preq = 1'b1;
		end else begin
			unique case (state_cur.step)
				STEP_WAIT: begin
					state_nxt.elapsed = elapsed_inc;
					if (pos_match) begin
						state_nxt.step = STEP_DONE;
					end else if (timed_out) begin
						state_nxt.step = STEP_RETRY;
					end
				end
				STEP_RETRY: begin
					state_nxt.elapsed = elapsed_inc;
					if (timed_out) begin
						if (state_cur.retry_cnt >= cfg.max_retries) begin
							state_nxt.step = STEP_FAIL;
						end else begin
							state_nxt.retry_cnt = state_cur.retry_cnt + 1'b1;
							state_nxt.elapsed   = '0;
							state_nxt.busy      = 1'b1;
							send                = 1'b1;
						end
					end else if (pos_match) begin
						state_nxt.step = STEP_DONE;
					end
				end
				STEP_DONE: begin
					state_nxt.busy = 1'b0;
					state_nxt.step = STEP_IDLE;
				end
				STEP_FAIL: begin
					state_nxt.busy = 1'b0;
					err            = 1'b1;
					state_nxt.step = STEP_IDLE;
				end
				default: begin
					state_nxt = state_cur;
				end
			endcase
		end
	end

	always_comb begin
		res_nxt.send_command  = send;
		res_nxt.command_out   = state_nxt.target;
		res_nxt.step_now      = step_code(state_nxt.step);
		res_nxt.busy_res      = state_nxt.busy;
		res_nxt.error_event   = err;
		res_nxt.power_request = preq;
	end

endmodule

`default_nettype wire

/* src/actuator_command_retry_supervisor_unit.sv */
// ----------------------------------------------------------------------------
// Actuator command retry supervisor
// Supervises one tilt actuator command with a poll timer and bounded retries.
//
//   Channel  Direction  Handshake     Content
//   item     in         valid/ready   operation, command, sensed position, power
//   result   out        valid/ready   send, command, step, busy, error, power req
//   cfg      in         write enable  timeout_ticks (0), max_retries (1)
//
// A transaction is registered in the input register on acceptance and its result
// in the result register, and one transaction is taken per cycle unless stalled.
// The state update happens as the registered transaction moves to the result
// register, which keeps successive transactions in order.
// A stalled result holds the input register; the input side then waits.
// Reset clears the state, the configuration to its defaults and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "actuator_command_retry_supervisor_unit_defines.svh"

module actuator_command_retry_supervisor_unit import acsu_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	acsu_item_if.sink              item,
	acsu_result_if.source          result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    result_s2;
	logic       advance;
	cfg_t       cfg_q;
	sup_state_t state_q;
	sup_state_t state_nxt;
	result_t    res_nxt;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready   = !valid_s1 || advance;
	assign result.valid = valid_s2;
	assign result.payload = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RESET;
			cfg_q.max_retries   <= RETRY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
				REG_MAX_RETRIES:   cfg_q.max_retries   <= cfg_wdata[RETRY_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.step      <= STEP_IDLE;
			state_q.busy      <= 1'b0;
			state_q.target    <= CMD_STOP;
			state_q.retry_cnt <= '0;
			state_q.elapsed   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	acsu_step_logic u_step_logic (
		.state_cur (state_q),
		.cfg       (cfg_q),
		.item_cur  (item_s1),
		.state_nxt (state_nxt),
		.res_nxt   (res_nxt)
	);

	`ACSU_ASSERT_SAME(a_error_ends_job, clk, arst_n,
		valid_s2 && result_s2.error_event,
		result_s2.step_now == STEP_CODE_IDLE && !result_s2.busy_res)
	`ACSU_ASSERT_SAME(a_send_while_busy, clk, arst_n,
		valid_s2 && result_s2.send_command, result_s2.busy_res)
	`ACSU_ASSERT_SAME(a_power_request_alone, clk, arst_n,
		valid_s2 && result_s2.power_request,
		!result_s2.send_command && !result_s2.error_event)
	`ACSU_ASSERT_NEXT(a_start_enters_wait, clk, arst_n,
		advance && item_s1.operation == OP_START,
		state_q.step == STEP_WAIT && state_q.retry_cnt == '0 && state_q.busy)

endmodule

`default_nettype wire
